// File: src/lrpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lrpa_pkg;

    localparam int COORD_BITS = 8;
    localparam int DIFF_W     = COORD_BITS + 2;
    localparam int DEC_W      = 12;
    localparam int STR_W      = 10;
    localparam int DIAG_W     = 11;
    localparam int ADDR_W     = 16;
    localparam int BPR_W      = 8;
    localparam int PPB_W      = 4;
    localparam int BIT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(COORD_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_ROW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_BYTE   = 2'd2;

    localparam logic [ADDR_W-1:0] FRAME_BASE_RST = 16'd0;
    localparam logic [BPR_W-1:0]  BYTES_ROW_RST  = 8'd40;
    localparam logic [PPB_W-1:0]  PIX_BYTE_RST   = 4'd6;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [ADDR_W-1:0]     byte_address;
        logic [BIT_W-1:0]      bit_index;
        logic                  last;
    } t_out_word;

    typedef struct packed {
        logic load_start;
        logic load_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic drawing;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: src/lrpa_path.sv
`timescale 1ns / 1ps
`default_nettype none
module lrpa_path (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [lrpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [lrpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  lrpa_pkg::t_in_word                  i_in_word,
    input  lrpa_pkg::t_cmd                      i_cmd,
    output lrpa_pkg::t_sts                      o_sts,
    output lrpa_pkg::t_out_word                 o_out_word,
    output logic                                o_valid,
    input  wire                                 i_ready
);

    localparam int CB = lrpa_pkg::COORD_BITS;
    localparam int DW = lrpa_pkg::DIFF_W;
    localparam int EW = lrpa_pkg::DEC_W;
    localparam int PW = lrpa_pkg::PPB_W;

    // configuration
    logic [lrpa_pkg::ADDR_W-1:0] r_base;
    logic [lrpa_pkg::BPR_W-1:0]  r_bpr;
    logic [PW-1:0]               r_ppb;

    // walk state
    logic                                r_drawing;
    logic                                r_swapped;
    logic                                r_down;
    logic [CB-1:0]                       r_major;
    logic [CB-1:0]                       r_minor;
    logic [CB-1:0]                       r_limit;
    logic                                r_last;
    logic signed [EW-1:0]                r_dec;
    logic signed [lrpa_pkg::STR_W-1:0]   r_str;
    logic signed [lrpa_pkg::DIAG_W-1:0]  r_diag;

    // divider
    logic [CB-1:0] r_quo;
    logic [PW-1:0] r_rem;

    logic                 r_out_valid;
    lrpa_pkg::t_out_word  r_out;

    // setup
    logic signed [DW-1:0] w_sx, w_sy, w_ex, w_ey;
    logic signed [DW-1:0] w_dx, w_dy, w_adx, w_ady;
    logic                 w_steep;
    logic signed [DW-1:0] w_p0, w_q0, w_p1, w_q1;
    logic signed [DW-1:0] w_p0o, w_q0o, w_p1o, w_q1o;
    logic signed [DW-1:0] w_dmaj, w_dmin;
    logic                 w_down;
    logic signed [EW-1:0] w_min_e, w_maj_e, w_dec0, w_diag_e;

    always_comb begin
        w_sx    = $signed({2'b00, i_in_word.start_x});
        w_sy    = $signed({2'b00, i_in_word.start_y});
        w_ex    = $signed({2'b00, i_in_word.end_x});
        w_ey    = $signed({2'b00, i_in_word.end_y});
        w_dx    = w_ex - w_sx;
        w_dy    = w_ey - w_sy;
        w_adx   = (w_dx < 0) ? -w_dx : w_dx;
        w_ady   = (w_dy < 0) ? -w_dy : w_dy;
        w_steep = w_ady > w_adx;
        w_p0    = w_steep ? w_sy : w_sx;
        w_q0    = w_steep ? w_sx : w_sy;
        w_p1    = w_steep ? w_ey : w_ex;
        w_q1    = w_steep ? w_ex : w_ey;
        // order endpoints so the major coordinate rises
        if (w_p1 < w_p0) begin
            w_p0o = w_p1;
            w_q0o = w_q1;
            w_p1o = w_p0;
            w_q1o = w_q0;
        end else begin
            w_p0o = w_p0;
            w_q0o = w_q0;
            w_p1o = w_p1;
            w_q1o = w_q1;
        end
        w_dmaj   = w_p1o - w_p0o;
        w_dmin   = w_q1o - w_q0o;
        w_down   = w_dmin <= 0;
        w_min_e  = EW'(w_dmin);
        w_maj_e  = EW'(w_dmaj);
        w_dec0   = w_down ? ((w_min_e <<< 1) + w_maj_e) : ((w_min_e <<< 1) - w_maj_e);
        w_diag_e = w_down ? ((w_min_e + w_maj_e) <<< 1) : ((w_min_e - w_maj_e) <<< 1);
    end

    // step
    logic                 w_straight;
    logic signed [EW-1:0] w_dec_next;
    logic [CB-1:0]        w_minor_next;
    logic [CB-1:0]        w_major_next;

    always_comb begin
        w_straight   = r_down ? !r_dec[EW-1] : (r_dec <= 0);
        w_dec_next   = r_dec + (w_straight ? EW'(r_str) : EW'(r_diag));
        w_minor_next = w_straight ? r_minor
                     : (r_down ? r_minor - CB'(1) : r_minor + CB'(1));
        w_major_next = r_major + CB'(1);
    end

    // pixel and address
    logic [CB-1:0]               w_x, w_y;
    logic [PW-1:0]               w_ppb;
    logic [PW:0]                 w_trial;
    logic                        w_ge;
    logic [PW:0]                 w_diff;
    logic [lrpa_pkg::ADDR_W-1:0] w_prod;
    logic [lrpa_pkg::ADDR_W-1:0] w_addr;
    logic [PW-1:0]               w_bit;

    always_comb begin
        w_x     = r_swapped ? r_minor : r_major;
        w_y     = r_swapped ? r_major : r_minor;
        w_ppb   = (r_ppb == '0) ? PW'(1) : r_ppb;
        w_trial = {r_rem, r_quo[CB-1]};
        w_ge    = w_trial >= {1'b0, w_ppb};
        w_diff  = w_trial - {1'b0, w_ppb};
        w_prod  = lrpa_pkg::ADDR_W'(r_bpr) * lrpa_pkg::ADDR_W'(w_y);
        w_addr  = r_base + w_prod + lrpa_pkg::ADDR_W'(r_quo);
        w_bit   = w_ppb - PW'(1) - r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= lrpa_pkg::FRAME_BASE_RST;
            r_bpr  <= lrpa_pkg::BYTES_ROW_RST;
            r_ppb  <= lrpa_pkg::PIX_BYTE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lrpa_pkg::REG_FRAME_BASE: r_base <= i_cfg_data[lrpa_pkg::ADDR_W-1:0];
                lrpa_pkg::REG_BYTES_ROW:  r_bpr  <= i_cfg_data[lrpa_pkg::BPR_W-1:0];
                lrpa_pkg::REG_PIX_BYTE:   r_ppb  <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing <= 1'b0;
        end else if (i_cmd.load_start) begin
            r_drawing <= w_p0o != w_p1o;
        end else if (i_cmd.load_step) begin
            r_drawing <= w_major_next != r_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_swapped <= w_steep;
            r_down    <= w_down;
            r_major   <= w_p0o[CB-1:0];
            r_minor   <= w_q0o[CB-1:0];
            r_limit   <= w_p1o[CB-1:0];
            r_last    <= w_p0o == w_p1o;
            r_dec     <= w_dec0;
            r_str     <= w_dmin <<< 1;
            r_diag    <= lrpa_pkg::DIAG_W'(w_diag_e);
        end else if (i_cmd.load_step) begin
            r_major   <= w_major_next;
            r_minor   <= w_minor_next;
            r_last    <= w_major_next == r_limit;
            r_dec     <= w_dec_next;
        end
    end

    // restoring divide of x by the pixels per byte, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= w_x;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[CB-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.pixel_x      <= w_x;
            r_out.pixel_y      <= w_y;
            r_out.byte_address <= w_addr;
            r_out.bit_index    <= w_bit[lrpa_pkg::BIT_W-1:0];
            r_out.last         <= r_last;
        end
    end

    assign o_sts.drawing  = r_drawing;
    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_out_word     = r_out;

endmodule
`default_nettype wire

// File: src/lrpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lrpa_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire             i_operation,
    output logic            o_ready,
    input  lrpa_pkg::t_sts  i_sts,
    output lrpa_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DINIT = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam logic [lrpa_pkg::DIV_CNT_W-1:0] CNT_LAST =
        lrpa_pkg::DIV_CNT_W'(lrpa_pkg::COORD_BITS - 1);

    logic [1:0]                       r_state, n_state;
    logic [lrpa_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                             w_accept;

    always_comb begin
        o_ready  = r_state == S_IDLE;
        w_accept = i_valid && o_ready;

        o_cmd.load_start = w_accept && (i_operation == lrpa_pkg::OP_START);
        o_cmd.load_step  = w_accept && (i_operation == lrpa_pkg::OP_STEP) && i_sts.drawing;
        o_cmd.div_init   = r_state == S_DINIT;
        o_cmd.div_step   = r_state == S_DIV;
        o_cmd.out_load   = (r_state == S_FIN) && i_sts.out_free;

        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                // a step with no line running is dropped
                if (o_cmd.load_start || o_cmd.load_step) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + lrpa_pkg::DIV_CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_start, o_cmd.load_step, o_cmd.div_init,
                  o_cmd.div_step, o_cmd.out_load}))
        else $error("lrpa_ctrl: more than one command at once");

    a_load_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_start || o_cmd.load_step) |=> (r_state == S_DINIT))
        else $error("lrpa_ctrl: load not followed by divider init");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_LAST) |=> (r_state == S_FIN))
        else $error("lrpa_ctrl: divider did not finish on count");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_sts.out_free) |=> (r_state == S_FIN))
        else $error("lrpa_ctrl: result lost while output full");
`endif

endmodule
`default_nettype wire

// File: src/line_rasterizer_pixel_address_top.sv
// Channel | Direction | Handshake            | Word
// --------+-----------+----------------------+---------------------------------------
// input   | in        | i_valid / o_ready    | i_in_word  (operation, endpoints)
// output  | out       | o_valid / i_ready    | o_out_word (pixel, address, bit, last)
// config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// Each word that yields a pixel runs through divider init, the bit-serial divide of x
// by the pixels per byte and the output load before the next input word is taken.
// A step word with no line running is taken and yields nothing.
// Reset is synchronous, active low; it clears the walk and restores register defaults.
// A stalled output holds its word; the next input word is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module line_rasterizer_pixel_address_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [lrpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [lrpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  lrpa_pkg::t_in_word                  i_in_word,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output lrpa_pkg::t_out_word                 o_out_word
);

    lrpa_pkg::t_cmd w_cmd;
    lrpa_pkg::t_sts w_sts;

    lrpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_in_word.operation),
        .o_ready     (o_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lrpa_path u_path (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_word  (o_out_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready)
    );

endmodule
`default_nettype wire
